/* hw/rtl/rau_pkg.sv */
`default_nettype none
package rau_pkg;

  localparam int unsigned OPERAND_WIDTH = 32;
  localparam int unsigned DEN_WIDTH = OPERAND_WIDTH - 1;
  localparam int unsigned WIDE_WIDTH = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned MAG_WIDTH = 2 * OPERAND_WIDTH;
  localparam int unsigned CNT_WIDTH = $clog2(MAG_WIDTH + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_BAD = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]                      operation;
    logic signed [OPERAND_WIDTH-1:0] left_num;
    logic [DEN_WIDTH-1:0]            left_den;
    logic signed [OPERAND_WIDTH-1:0] right_num;
    logic [DEN_WIDTH-1:0]            right_den;
  } in_item_t;

  typedef struct packed {
    logic signed [OPERAND_WIDTH-1:0] result_num;
    logic [DEN_WIDTH-1:0]            result_den;
    logic                            overflow;
  } out_item_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_FORM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_CHECK,
    ST_OUT
  } state_t;

  // Datapath commands from the controller
  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic form;
    logic gcd_start;
    logic gcd_step;
    logic div_start_n;
    logic div_start_d;
    logic div_step;
    logic check;
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic bad_op;
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

/* hw/rtl/rational_arithmetic_unit_core.sv */
// Rational arithmetic unit: add, multiply or divide two rationals and reduce.
// Input channel in_valid/in_stall/in_item carries the operation and operands;
// result channel out_valid/out_stall/out_item carries the reduced numerator,
// denominator and overflow flag. One item is in flight at a time: in_stall is
// low only while idle. Each item yields exactly one result.
// Steps: two cross products in turn on one shared multiplier, a form step,
// then Euclid's gcd with each remainder taken by a bit-serial divider, then
// two divisions of numerator and denominator by the gcd and a check step.
// An unused operation code gives 0/0 with overflow.
// The next item is accepted at the earliest in the cycle after the result is taken.
// The result is held in a register with out_valid high until out_stall is low;
// no new item is taken meanwhile.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any
// item in flight.
`default_nettype none
module rational_arithmetic_unit_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rau_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rau_pkg::out_item_t      out_item
);

  rau_pkg::cmd_t    cmd;
  rau_pkg::status_t sts;
  rau_pkg::cmd_t    cmd_g;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // gcd stepping continues until the datapath reports completion
  always_comb begin
    cmd_g = cmd;
  end

  rau_dp u_dp (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd_g),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

/* hw/rtl/rau_ctrl.sv */
`default_nettype none
module rau_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire rau_pkg::status_t sts,
  output rau_pkg::cmd_t       cmd
);

  rau_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      rau_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = rau_pkg::ST_MUL_A;
        end
      end
      rau_pkg::ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = rau_pkg::ST_MUL_B;
      end
      rau_pkg::ST_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = rau_pkg::ST_FORM;
      end
      rau_pkg::ST_FORM: begin
        if (sts.bad_op) begin
          cmd.check = 1'b1;
          state_nxt = rau_pkg::ST_OUT;
        end else begin
          cmd.form = 1'b1;
          state_nxt = rau_pkg::ST_GCD;
        end
      end
      rau_pkg::ST_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_start_n = 1'b1;
          state_nxt = rau_pkg::ST_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      rau_pkg::ST_DIVN: begin
        if (sts.div_done) begin
          cmd.div_start_d = 1'b1;
          state_nxt = rau_pkg::ST_DIVD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      rau_pkg::ST_DIVD: begin
        if (sts.div_done) begin
          state_nxt = rau_pkg::ST_CHECK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      rau_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = rau_pkg::ST_OUT;
      end
      rau_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = rau_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rau_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == rau_pkg::ST_MUL_A)
    else $error("item accepted outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("accept while result pending");
`endif

endmodule
`default_nettype wire

/* hw/rtl/rau_dp.sv */
`default_nettype none
module rau_dp (
  input  wire logic              clk,
  input  wire rau_pkg::in_item_t in_item,
  input  wire rau_pkg::cmd_t     cmd,
  output rau_pkg::status_t       sts,
  output rau_pkg::out_item_t     out_item
);

  localparam int unsigned W = rau_pkg::OPERAND_WIDTH;
  localparam int unsigned DW = rau_pkg::DEN_WIDTH;
  localparam int unsigned MW = rau_pkg::MAG_WIDTH;
  localparam int unsigned XW = rau_pkg::WIDE_WIDTH;
  localparam int unsigned CW = rau_pkg::CNT_WIDTH;
  localparam logic [MW-1:0] POS_LIMIT = {{(MW-DW){1'b0}}, {DW{1'b1}}};
  localparam logic [MW-1:0] NEG_LIMIT = POS_LIMIT + 1'b1;

  rau_pkg::in_item_t item_r;
  logic signed [XW-1:0] pa_r, pb_r;
  logic signed [XW-1:0] prd;
  logic signed [W:0] mul_x, mul_y;
  logic signed [W:0] lnum, rnum, lden, rden;
  logic neg_r;
  logic [MW-1:0] mn_r, md_r;
  logic [MW-1:0] ga_r, gb_r, g_r;
  logic [MW-1:0] quo_r, rem_r, dvd_r;
  logic [CW-1:0] cnt_r;
  logic [MW-1:0] qn_r;
  logic gcd_busy_r;
  logic gcd_done_r;
  rau_pkg::out_item_t res_r;
  logic signed [XW-1:0] n_w, d_w;
  logic [MW:0] rem_sh;

  assign lnum = {item_r.left_num[W-1], item_r.left_num};
  assign rnum = {item_r.right_num[W-1], item_r.right_num};
  assign lden = {2'b00, item_r.left_den};
  assign rden = {2'b00, item_r.right_den};

  // Shared multiplier, operands picked per step; ld*rd when nothing else is asked
  always_comb begin
    mul_x = lden;
    mul_y = rden;
    case (rau_pkg::op_t'(item_r.operation))
      rau_pkg::OP_ADD: begin
        if (cmd.mul_a) begin
          mul_x = lnum;
        end else if (cmd.mul_b) begin
          mul_x = rnum;
          mul_y = lden;
        end
      end
      rau_pkg::OP_MUL: begin
        if (cmd.mul_a) begin
          mul_x = lnum;
          mul_y = rnum;
        end
      end
      rau_pkg::OP_DIV: begin
        if (cmd.mul_a) begin
          mul_x = lnum;
        end else if (cmd.mul_b) begin
          mul_y = rnum;
        end
      end
      default: begin
        mul_x = lden;
        mul_y = rden;
      end
    endcase
  end

  assign prd = XW'(mul_x * mul_y);

  // Form numerator and denominator
  always_comb begin
    n_w = pa_r;
    d_w = pb_r;
    if (item_r.operation == rau_pkg::OP_ADD) begin
      n_w = pa_r + pb_r;
      d_w = prd;
    end else if (item_r.operation == rau_pkg::OP_MUL) begin
      n_w = pa_r;
      d_w = pb_r;
    end
    if (d_w < 0) begin
      n_w = -n_w;
      d_w = -d_w;
    end
  end

  // One restoring division step shared by gcd remainder and final divides
  assign rem_sh = {rem_r, dvd_r[MW-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.mul_a) begin
      pa_r <= prd;
    end
    if (cmd.mul_b) begin
      pb_r <= prd;
    end
    if (cmd.form) begin
      neg_r <= n_w < 0;
      mn_r <= (n_w < 0) ? MW'(-n_w) : MW'(n_w);
      md_r <= MW'(d_w);
      ga_r <= (n_w < 0) ? MW'(-n_w) : MW'(n_w);
      gb_r <= MW'(d_w);
      gcd_busy_r <= 1'b0;
      gcd_done_r <= 1'b0;
    end
    // Euclid: each remainder via the bit-serial divider
    if (cmd.gcd_step) begin
      if (!gcd_busy_r) begin
        if (gb_r == '0) begin
          g_r <= (ga_r == '0) ? MW'(1) : ga_r;
          gcd_done_r <= 1'b1;
        end else begin
          dvd_r <= ga_r;
          rem_r <= '0;
          cnt_r <= CW'(MW);
          gcd_busy_r <= 1'b1;
        end
      end else if (cnt_r != '0) begin
        dvd_r <= {dvd_r[MW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (rem_sh >= {1'b0, gb_r}) begin
          rem_r <= MW'(rem_sh - {1'b0, gb_r});
        end else begin
          rem_r <= rem_sh[MW-1:0];
        end
      end else begin
        ga_r <= gb_r;
        gb_r <= rem_r;
        gcd_busy_r <= 1'b0;
      end
    end
    if (cmd.div_start_n || cmd.div_start_d) begin
      dvd_r <= cmd.div_start_n ? mn_r : md_r;
      rem_r <= '0;
      quo_r <= '0;
      cnt_r <= CW'(MW);
      if (cmd.div_start_d) begin
        qn_r <= quo_r;
      end
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[MW-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (rem_sh >= {1'b0, g_r}) begin
        rem_r <= MW'(rem_sh - {1'b0, g_r});
        quo_r <= {quo_r[MW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[MW-1:0];
        quo_r <= {quo_r[MW-2:0], 1'b0};
      end
    end
    // Range check and result register
    if (cmd.check) begin
      if (item_r.operation == rau_pkg::OP_BAD ||
          (neg_r ? qn_r > NEG_LIMIT : qn_r > POS_LIMIT) || quo_r > POS_LIMIT) begin
        res_r <= '{result_num: '0, result_den: '0, overflow: 1'b1};
      end else begin
        res_r.result_num <= neg_r ? W'(-qn_r) : W'(qn_r);
        res_r.result_den <= DW'(quo_r);
        res_r.overflow <= 1'b0;
      end
    end
  end

  // gcd is done once the divisor side reached zero and the gcd is latched
  assign sts = '{bad_op:   (item_r.operation == rau_pkg::OP_BAD),
                 gcd_done: gcd_done_r,
                 div_done: (cnt_r == '0)};
  assign out_item = res_r;

endmodule
`default_nettype wire
